// ===== rtl/core/ldcbs_pkg.sv =====
package ldcbs_pkg;

  localparam int unsigned LiftCount = 51;

  localparam logic [13:0] MaxSeg1 = 14'd8448;
  localparam logic [13:0] MaxSeg2 = 14'd3840;
  localparam logic [13:0] SegDiv1 = 14'd8424;
  localparam logic [13:0] SegDiv2 = 14'd3816;
  localparam logic [21:0] Recip1  = 22'((64'd1 << 32) / 64'd8424);
  localparam logic [21:0] Recip2  = 22'((64'd1 << 32) / 64'd3816);

  localparam logic [20:0] SmallTb   = 21'd292;
  localparam logic [20:0] CrcTb     = 21'd3824;
  localparam logic [10:0] RateLow   = 11'd256;
  localparam logic [10:0] RateMid   = 11'd686;
  localparam logic [4:0]  CrcShort  = 5'd16;
  localparam logic [4:0]  CrcLong   = 5'd24;
  localparam logic [1:0]  Graph1    = 2'd1;
  localparam logic [1:0]  Graph2    = 2'd2;
  localparam int unsigned QuoBits   = 14;

  localparam logic [8:0] LIFT_TAB [LiftCount] = '{
    9'd2,   9'd3,   9'd4,   9'd5,   9'd6,   9'd7,   9'd8,   9'd9,   9'd10,  9'd11,
    9'd12,  9'd13,  9'd14,  9'd15,  9'd16,  9'd18,  9'd20,  9'd22,  9'd24,  9'd26,
    9'd28,  9'd30,  9'd32,  9'd36,  9'd40,  9'd44,  9'd48,  9'd52,  9'd56,  9'd60,
    9'd64,  9'd72,  9'd80,  9'd88,  9'd96,  9'd104, 9'd112, 9'd120, 9'd128, 9'd144,
    9'd160, 9'd176, 9'd192, 9'd208, 9'd224, 9'd240, 9'd256, 9'd288, 9'd320, 9'd352,
    9'd384
  };

  typedef struct packed {
    logic                 valid;
    logic [1:0]           graph;
    logic [4:0]           tbcrc;
    logic [21:0]          b;
    logic [21:0]          x;
    logic [11:0]          qe;
    logic [9:0]           c;
    logic [21:0]          bout;
    logic [12:0]          total;
    logic [22:0]          n;
    logic [LiftCount-1:0] ge;
    logic [8:0]           zc;
    logic                 nofit;
    logic [22:0]          rem;
    logic [QuoBits-1:0]   quo;
  } item_t;

endpackage

// ===== rtl/core/ldcbs_front.sv =====
module ldcbs_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req,
  input  logic [20:0]          tb_bits,
  input  logic [10:0]          rate_q10,
  output ldcbs_pkg::item_t     item_o
);

  ldcbs_pkg::item_t s1_r, s1_nxt, s2_r, s2_nxt, s3_r, s3_nxt, s4_r, s4_nxt;

  logic [43:0] prod;
  logic [13:0] dsel;
  logic [26:0] back;
  logic [3:0]  kb;

  // graph, tb crc, B
  always_comb begin
    s1_nxt = '0;
    s1_nxt.valid = req;
    s1_nxt.graph = (tb_bits <= ldcbs_pkg::SmallTb || rate_q10 <= ldcbs_pkg::RateLow ||
                    (tb_bits <= ldcbs_pkg::CrcTb && rate_q10 <= ldcbs_pkg::RateMid)) ?
                   ldcbs_pkg::Graph2 : ldcbs_pkg::Graph1;
    s1_nxt.tbcrc = (tb_bits <= ldcbs_pkg::CrcTb) ? ldcbs_pkg::CrcShort : ldcbs_pkg::CrcLong;
    s1_nxt.b     = 22'(tb_bits) + 22'(s1_nxt.tbcrc);
  end

  // block count estimate by reciprocal
  always_comb begin
    s2_nxt = s1_r;
    s2_nxt.x = s1_r.b + ((s1_r.graph == ldcbs_pkg::Graph1) ?
               22'(ldcbs_pkg::SegDiv1 - 14'd1) : 22'(ldcbs_pkg::SegDiv2 - 14'd1));
    prod = 44'(s2_nxt.x) * 44'((s1_r.graph == ldcbs_pkg::Graph1) ?
           ldcbs_pkg::Recip1 : ldcbs_pkg::Recip2);
    s2_nxt.qe = prod[43:32];
  end

  // correct estimate
  always_comb begin
    s3_nxt = s2_r;
    dsel = (s2_r.graph == ldcbs_pkg::Graph1) ? ldcbs_pkg::SegDiv1 : ldcbs_pkg::SegDiv2;
    back = 27'(s2_r.qe) * 27'(dsel) + 27'(dsel);
    if (s2_r.b <= 22'((s2_r.graph == ldcbs_pkg::Graph1) ?
                      ldcbs_pkg::MaxSeg1 : ldcbs_pkg::MaxSeg2)) begin
      s3_nxt.c = 10'd1;
    end else if (27'(s2_r.x) >= back) begin
      s3_nxt.c = 10'(s2_r.qe + 12'd1);
    end else begin
      s3_nxt.c = 10'(s2_r.qe);
    end
  end

  // Kb, totals, divider numerator
  always_comb begin
    s4_nxt = s3_r;
    if (s3_r.graph == ldcbs_pkg::Graph1) kb = 4'd0;
    else if (s3_r.b > 22'd640) kb = 4'd10;
    else if (s3_r.b > 22'd560) kb = 4'd9;
    else if (s3_r.b > 22'd192) kb = 4'd8;
    else kb = 4'd6;
    s4_nxt.total = (s3_r.graph == ldcbs_pkg::Graph1) ? 13'(s3_r.c) * 13'd22 :
                   13'(s3_r.c) * 13'(kb);
    s4_nxt.bout  = s3_r.b + ((s3_r.c > 10'd1) ? 22'(s3_r.c) * 22'd24 : 22'd0);
    s4_nxt.n     = 23'(s3_r.b) + 23'(s3_r.c) - 23'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
      s4_r.valid <= 1'b0;
    end else begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
    end
  end

  assign item_o = s4_r;

endmodule

// ===== rtl/core/ldcbs_lift.sv =====
module ldcbs_lift (
  input  logic             clk,
  input  logic             rst_n,
  input  ldcbs_pkg::item_t item_i,
  output ldcbs_pkg::item_t item_o
);

  ldcbs_pkg::item_t s5_r, s5_nxt, s6_r, s6_nxt;

  // product is monotonic in the table index, so flags form a thermometer
  always_comb begin
    s5_nxt = item_i;
    for (int i = 0; i < ldcbs_pkg::LiftCount; i++) begin
      s5_nxt.ge[i] = (23'(ldcbs_pkg::LIFT_TAB[i]) * 23'(item_i.total)) >= 23'(item_i.bout);
    end
  end

  always_comb begin
    s6_nxt = s5_r;
    s6_nxt.zc = '0;
    for (int i = 0; i < ldcbs_pkg::LiftCount; i++) begin
      if (s5_r.ge[i] && (i == 0 || !s5_r.ge[(i == 0) ? 0 : i - 1])) begin
        s6_nxt.zc = s6_nxt.zc | ldcbs_pkg::LIFT_TAB[i];
      end
    end
    s6_nxt.nofit = !s5_r.ge[ldcbs_pkg::LiftCount-1];
    s6_nxt.rem   = s5_r.n;
    s6_nxt.quo   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_r.valid <= 1'b0;
      s6_r.valid <= 1'b0;
    end else begin
      s5_r <= s5_nxt;
      s6_r <= s6_nxt;
    end
  end

  assign item_o = s6_r;

endmodule

// ===== rtl/core/ldcbs_div.sv =====
module ldcbs_div (
  input  logic             clk,
  input  logic             rst_n,
  input  ldcbs_pkg::item_t item_i,
  output ldcbs_pkg::item_t item_o
);

  localparam int unsigned Steps = ldcbs_pkg::QuoBits;

  ldcbs_pkg::item_t stg_r [Steps];
  ldcbs_pkg::item_t stg_nxt [Steps];

  // restoring division, one quotient bit per stage, msb first
  for (genvar j = 0; j < Steps; j++) begin : g_step
    ldcbs_pkg::item_t prev;
    logic [23:0]      dsh;
    assign prev = (j == 0) ? item_i : stg_r[(j == 0) ? 0 : j - 1];
    assign dsh  = 24'(prev.c) << (Steps - 1 - j);
    always_comb begin
      stg_nxt[j] = prev;
      if (24'(prev.rem) >= dsh) begin
        stg_nxt[j].rem = prev.rem - 23'(dsh);
        stg_nxt[j].quo[Steps-1-j] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) stg_r[j].valid <= 1'b0;
      else stg_r[j] <= stg_nxt[j];
    end
  end

  assign item_o = stg_r[Steps-1];

endmodule

// ===== rtl/core/ldpc_cb_segmentation_params.sv =====
// LDPC code block segmentation parameters.
// Request: pulse start with in_tb_bits and in_code_rate_q10; it is taken at
// the clock edge where start is high and busy is low. busy is always low, so
// a new request can be given in every cycle.
// Result: after the stages below, out_valid is high for one cycle with all
// out_ fields; results come in request order, one per cycle at most.
// Throughput: one request per cycle. Latency is set by four front stages
// (graph/CRC, reciprocal multiply, block count correction, totals), two
// lifting-size search stages, a 14-stage one-bit-per-stage divider for the
// per-block size, and the output register.
// Reset: synchronous, active low; clears every stage valid bit, so no result
// appears from requests in flight. The receiver cannot stall; each result is
// shown for exactly one cycle.
// no_fit is set, with all other fields zero, if no lifting size fits.
module ldpc_cb_segmentation_params (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [20:0] in_tb_bits,
  input  logic [10:0] in_code_rate_q10,
  output logic        out_valid,
  output logic [1:0]  out_graph_sel,
  output logic [4:0]  out_tb_crc_len,
  output logic [9:0]  out_block_count,
  output logic [8:0]  out_lift_size,
  output logic [13:0] out_block_len,
  output logic [14:0] out_codeword_len,
  output logic [4:0]  out_block_crc_len,
  output logic [13:0] out_info_bits,
  output logic [8:0]  out_pad_bits,
  output logic [13:0] out_filler_bits,
  output logic [13:0] out_last_info_bits,
  output logic        out_no_fit
);

  ldcbs_pkg::item_t front_q, lift_q, div_q;

  logic        valid_r, valid_nxt;
  logic [1:0]  graph_r, graph_nxt;
  logic [4:0]  tbcrc_r, tbcrc_nxt;
  logic [9:0]  cnt_r, cnt_nxt;
  logic [8:0]  zc_r, zc_nxt;
  logic [13:0] k_r, k_nxt;
  logic [14:0] cw_r, cw_nxt;
  logic [4:0]  bcrc_r, bcrc_nxt;
  logic [13:0] info_r, info_nxt;
  logic [8:0]  pad_r, pad_nxt;
  logic [13:0] fill_r, fill_nxt;
  logic [13:0] last_r, last_nxt;
  logic        nofit_r, nofit_nxt;

  logic [14:0] kp;
  logic [13:0] kk;
  logic [9:0]  padw;
  logic [15:0] need;

  assign busy = 1'b0;

  ldcbs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (start),
    .tb_bits  (in_tb_bits),
    .rate_q10 (in_code_rate_q10),
    .item_o   (front_q)
  );

  ldcbs_lift u_lift (
    .clk    (clk),
    .rst_n  (rst_n),
    .item_i (front_q),
    .item_o (lift_q)
  );

  ldcbs_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .item_i (lift_q),
    .item_o (div_q)
  );

  always_comb begin
    valid_nxt = div_q.valid;
    kk        = (div_q.graph == ldcbs_pkg::Graph1) ? 14'(div_q.zc) * 14'd22 :
                14'(div_q.zc) * 14'd10;
    bcrc_nxt  = (div_q.c > 10'd1) ? ldcbs_pkg::CrcLong : 5'd0;
    kp        = 15'(div_q.quo) + 15'(bcrc_nxt);
    // n = B + C - 1 = quo*C + rem, so pad = C - 1 - rem
    padw      = div_q.c - 10'd1 - 10'(div_q.rem);
    need      = 16'(div_q.tbcrc) + 16'(padw);
    graph_nxt = div_q.graph;
    tbcrc_nxt = div_q.tbcrc;
    cnt_nxt   = div_q.c;
    zc_nxt    = div_q.zc;
    k_nxt     = kk;
    cw_nxt    = (div_q.graph == ldcbs_pkg::Graph1) ? 15'(kk) * 15'd3 : 15'(kk) * 15'd5;
    info_nxt  = div_q.quo;
    pad_nxt   = padw[8:0];
    fill_nxt  = (15'(kk) >= kp) ? 14'(15'(kk) - kp) : 14'd0;
    last_nxt  = (16'(div_q.quo) >= need) ? 14'(16'(div_q.quo) - need) : 14'd0;
    nofit_nxt = div_q.nofit;
    if (div_q.nofit) begin
      graph_nxt = '0;
      tbcrc_nxt = '0;
      cnt_nxt   = '0;
      zc_nxt    = '0;
      k_nxt     = '0;
      cw_nxt    = '0;
      bcrc_nxt  = '0;
      info_nxt  = '0;
      pad_nxt   = '0;
      fill_nxt  = '0;
      last_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    graph_r <= graph_nxt;
    tbcrc_r <= tbcrc_nxt;
    cnt_r   <= cnt_nxt;
    zc_r    <= zc_nxt;
    k_r     <= k_nxt;
    cw_r    <= cw_nxt;
    bcrc_r  <= bcrc_nxt;
    info_r  <= info_nxt;
    pad_r   <= pad_nxt;
    fill_r  <= fill_nxt;
    last_r  <= last_nxt;
    nofit_r <= nofit_nxt;
  end

  assign out_valid          = valid_r;
  assign out_graph_sel      = graph_r;
  assign out_tb_crc_len     = tbcrc_r;
  assign out_block_count    = cnt_r;
  assign out_lift_size      = zc_r;
  assign out_block_len      = k_r;
  assign out_codeword_len   = cw_r;
  assign out_block_crc_len  = bcrc_r;
  assign out_info_bits      = info_r;
  assign out_pad_bits       = pad_r;
  assign out_filler_bits    = fill_r;
  assign out_last_info_bits = last_r;
  assign out_no_fit         = nofit_r;

endmodule

// ===== verif/tb_ldpc_cb_segmentation_params.sv =====
`timescale 1ns / 100ps

typedef struct {
  logic [1:0]  graph_sel;
  logic [4:0]  tb_crc_len;
  logic [9:0]  block_count;
  logic [8:0]  lift_size;
  logic [13:0] block_len;
  logic [14:0] codeword_len;
  logic [4:0]  block_crc_len;
  logic [13:0] info_bits;
  logic [8:0]  pad_bits;
  logic [13:0] filler_bits;
  logic [13:0] last_info_bits;
  logic        no_fit;
} seg_params_t;

class seg_scoreboard;
  seg_params_t pending[$];
  int unsigned errors = 0;
  int unsigned checked = 0;
  int unsigned graph2_seen = 0;
  int unsigned multi_seen = 0;

  function seg_params_t segment(logic [20:0] tb_bits, logic [10:0] rate);
    seg_params_t r;
    longint unsigned a, rq, g, l, b, maxseg, c, kb, bcrc, bout, zc, k, cw, kp, info, pad;
    a = tb_bits;
    rq = rate;
    zc = 0;
    g = (a <= ldcbs_pkg::SmallTb || rq <= ldcbs_pkg::RateLow ||
         (a <= ldcbs_pkg::CrcTb && rq <= ldcbs_pkg::RateMid)) ? 2 : 1;
    l = (a <= ldcbs_pkg::CrcTb) ? ldcbs_pkg::CrcShort : ldcbs_pkg::CrcLong;
    b = a + l;
    maxseg = (g == 1) ? ldcbs_pkg::MaxSeg1 : ldcbs_pkg::MaxSeg2;
    c = (b <= maxseg) ? 1 : (b + maxseg - 25) / (maxseg - 24);
    if (g == 1) kb = 22;
    else if (b > 640) kb = 10;
    else if (b > 560) kb = 9;
    else if (b > 192) kb = 8;
    else kb = 6;
    bcrc = (c > 1) ? 24 : 0;
    bout = b + bcrc * c;
    for (int i = 0; i < ldcbs_pkg::LiftCount; i++) begin
      if (zc == 0 && ldcbs_pkg::LIFT_TAB[i] * c * kb >= bout) zc = ldcbs_pkg::LIFT_TAB[i];
    end
    r = '{default: '0};
    if (zc == 0) begin
      r.no_fit = 1'b1;
      return r;
    end
    k = ((g == 1) ? 22 : 10) * zc;
    cw = k * ((g == 1) ? 3 : 5);
    kp = (bout + c - 1) / c;
    info = kp - bcrc;
    pad = kp * c - bout;
    r.graph_sel = g[1:0];
    r.tb_crc_len = l[4:0];
    r.block_count = c[9:0];
    r.lift_size = zc[8:0];
    r.block_len = k[13:0];
    r.codeword_len = cw[14:0];
    r.block_crc_len = bcrc[4:0];
    r.info_bits = info[13:0];
    r.pad_bits = pad[8:0];
    r.filler_bits = (k >= kp) ? 14'(k - kp) : '0;
    r.last_info_bits = (info >= l + pad) ? 14'(info - l - pad) : '0;
    return r;
  endfunction

  function void note_request(logic [20:0] tb_bits, logic [10:0] rate);
    seg_params_t r;
    r = segment(tb_bits, rate);
    if (r.graph_sel == ldcbs_pkg::Graph2) graph2_seen++;
    if (r.block_count > 1) multi_seen++;
    pending.push_back(r);
  endfunction

  function void cmp(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, actual %0d", name, e, a);
      errors++;
    end
  endfunction

  function void check_result(seg_params_t act);
    seg_params_t e;
    if (pending.size() == 0) begin
      $error("result with no request pending");
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    cmp("graph_sel", e.graph_sel, act.graph_sel);
    cmp("tb_crc_len", e.tb_crc_len, act.tb_crc_len);
    cmp("block_count", e.block_count, act.block_count);
    cmp("lift_size", e.lift_size, act.lift_size);
    cmp("block_len", e.block_len, act.block_len);
    cmp("codeword_len", e.codeword_len, act.codeword_len);
    cmp("block_crc_len", e.block_crc_len, act.block_crc_len);
    cmp("info_bits", e.info_bits, act.info_bits);
    cmp("pad_bits", e.pad_bits, act.pad_bits);
    cmp("filler_bits", e.filler_bits, act.filler_bits);
    cmp("last_info_bits", e.last_info_bits, act.last_info_bits);
    cmp("no_fit", e.no_fit, act.no_fit);
  endfunction
endclass

module tb_ldpc_cb_segmentation_params;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [20:0] in_tb_bits = '0;
  logic [10:0] in_code_rate_q10 = '0;
  logic        out_valid;
  logic [1:0]  out_graph_sel;
  logic [4:0]  out_tb_crc_len;
  logic [9:0]  out_block_count;
  logic [8:0]  out_lift_size;
  logic [13:0] out_block_len;
  logic [14:0] out_codeword_len;
  logic [4:0]  out_block_crc_len;
  logic [13:0] out_info_bits;
  logic [8:0]  out_pad_bits;
  logic [13:0] out_filler_bits;
  logic [13:0] out_last_info_bits;
  logic        out_no_fit;

  seg_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned sent = 0;

  ldpc_cb_segmentation_params DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    seg_params_t act;
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
    if (rst_n && out_valid) begin
      act.graph_sel = out_graph_sel;
      act.tb_crc_len = out_tb_crc_len;
      act.block_count = out_block_count;
      act.lift_size = out_lift_size;
      act.block_len = out_block_len;
      act.codeword_len = out_codeword_len;
      act.block_crc_len = out_block_crc_len;
      act.info_bits = out_info_bits;
      act.pad_bits = out_pad_bits;
      act.filler_bits = out_filler_bits;
      act.last_info_bits = out_last_info_bits;
      act.no_fit = out_no_fit;
      sb.check_result(act);
    end
    if (rst_n && start && !busy) sb.note_request(in_tb_bits, in_code_rate_q10);
  end

  task automatic send_request(logic [20:0] tb, logic [10:0] rate);
    bit taken;
    start <= 1'b1;
    in_tb_bits <= tb;
    in_code_rate_q10 <= rate;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    sent++;
  endtask

  task automatic idle(int unsigned n);
    repeat (n) begin
      start <= 1'b0;
      in_tb_bits <= 21'($urandom);
      in_code_rate_q10 <= 11'($urandom);
      @(posedge clk);
    end
  endtask

  function automatic logic [20:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 21'($urandom);
      1, 2: return 21'($urandom_range(1, 700));
      3: return 21'($urandom_range(701, 3900));
      4: return 21'($urandom_range(3790, 3860));
      5: return 21'($urandom_range(270, 310));
      6: return 21'($urandom_range(8380, 8500) + $urandom_range(0, 3) * 8424);
      default: return 21'($urandom_range(1, 1277992));
    endcase
  endfunction

  function automatic logic [10:0] pick_rate();
    case ($urandom_range(0, 7))
      0: return 11'($urandom);
      1: return 11'($urandom_range(250, 262));
      2: return 11'($urandom_range(680, 692));
      default: return 11'($urandom_range(0, 1024));
    endcase
  endfunction

  initial begin
    logic [20:0] sizes[] = '{0, 1, 292, 293, 3824, 3825, 8424, 8425, 1277992, 21'h1FFFFF};
    logic [10:0] rates[] = '{0, 256, 257, 686, 687, 1024, 11'h7FF};
    bit drained = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (sizes[i]) send_request(sizes[i], rates[i % rates.size()]);
    foreach (rates[i]) send_request(21'd3000, rates[i]);
    send_request(21'd600, 11'd900);
    send_request(21'd200, 11'd900);
    idle(1);
    while (sent < 1475) begin
      int unsigned burst;
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      repeat (burst) send_request(pick_size(), pick_rate());
      if (!drained && sent > 700) begin
        drained = 1'b1;
        idle(1);
        while (sb.pending.size() != 0) @(posedge clk);
      end
      idle($urandom_range(1, 12));
    end
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("%0d requests, %0d results checked: %0d on graph 2, %0d segmented",
             sent, sb.checked, sb.graph2_seen, sb.multi_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
